// ===== hdl/csfe_pkg.sv =====
// Shared types, constants, breakpoint tables and microprogram for the compressor speed block.
package csfe_pkg;

  localparam int TAB_DEPTH     = 16;
  localparam int IDX_W         = 4;
  localparam int TARGET_POINTS = 10;
  localparam int SPEED_POINTS  = 13;

  localparam int ERR_W      = 12;
  localparam int EVAP_W     = 12;
  localparam int SPD_W      = 13;
  localparam int TGT_W      = 7;
  localparam int DIFF_W     = 12;
  localparam int RAMP_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int XW     = 13;
  localparam int YW     = 14;
  localparam int SW     = 15;
  localparam int NUM_W  = 14;
  localparam int DEN_W  = 8;
  localparam int STEP_W = 4;

  localparam int TGT_X [TAB_DEPTH] = '{-10, 0, 10, 20, 30, 40, 50, 60, 70, 80,
                                       80, 80, 80, 80, 80, 80};
  localparam int TGT_Y [TAB_DEPTH] = '{105, 102, 92, 77, 60, 35, 18, 8, 2, 0,
                                       0, 0, 0, 0, 0, 0};
  localparam int SPD_X [TAB_DEPTH] = '{-40, -30, -20, -10, 0, 10, 20, 30, 40, 50,
                                       60, 70, 80, 80, 80, 80};
  localparam int SPD_Y [TAB_DEPTH] = '{2000, 2000, 2000, 2000, 2000, 2000, 2300, 2850,
                                       4100, 5000, 5550, 5900, 6000, 6000, 6000, 6000};

  localparam logic [SPD_W-1:0] SPEED_MAX = SPD_W'(6000);

  localparam logic signed [EVAP_W-1:0] FROST_ON_RST  = EVAP_W'(0);
  localparam logic signed [EVAP_W-1:0] FROST_OFF_RST = EVAP_W'(10);
  localparam logic signed [EVAP_W-1:0] OVERHEAT_RST  = EVAP_W'(800);
  localparam logic [RAMP_W-1:0]        RAMP_RST      = RAMP_W'(40);
  localparam logic [SPD_W-1:0]         START_RST     = SPD_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FROST_ON  = 3'd0,
    CFG_FROST_OFF = 3'd1,
    CFG_OVERHEAT  = 3'd2,
    CFG_RAMP      = 3'd3,
    CFG_START     = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_CLAMP,
    OP_SEARCH,
    OP_SETUP,
    OP_DIV_START,
    OP_ADDQ,
    OP_TARGET,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_CLAMPED,
    C_MORE,
    C_FLAT,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e                op;
    logic               sel;
    cond_e              cond;
    logic [STEP_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic clamped;
    logic more;
    logic flat;
    logic div_busy;
  } stat_t;

  typedef struct packed {
    logic signed [EVAP_W-1:0] frost_on;
    logic signed [EVAP_W-1:0] frost_off;
    logic signed [EVAP_W-1:0] overheat;
    logic [RAMP_W-1:0]        ramp;
    logic [SPD_W-1:0]         start;
  } cfg_t;

  typedef struct packed {
    logic [SPD_W-1:0]         speed;
    logic [TGT_W-1:0]         target;
    logic signed [DIFF_W-1:0] diff;
  } res_t;

  function automatic logic signed [XW-1:0] tab_x(input logic sel,
                                                 input logic [IDX_W-1:0] idx);
    return sel ? XW'(SPD_X[idx]) : XW'(TGT_X[idx]);
  endfunction

  function automatic logic signed [YW-1:0] tab_y(input logic sel,
                                                 input logic [IDX_W-1:0] idx);
    return sel ? YW'(SPD_Y[idx]) : YW'(TGT_Y[idx]);
  endfunction

  function automatic logic [IDX_W-1:0] last_idx(input logic sel);
    return sel ? IDX_W'(SPEED_POINTS - 1) : IDX_W'(TARGET_POINTS - 1);
  endfunction

  function automatic ctrl_t mk(input op_e op, input logic sel, input cond_e cond,
                               input int tgt);
    ctrl_t c;
    c.op     = op;
    c.sel    = sel;
    c.cond   = cond;
    c.target = STEP_W'(tgt);
    return c;
  endfunction

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      4'd0:    c = mk(OP_LATCH,     1'b0, C_NO_IN,    0);
      4'd1:    c = mk(OP_CLAMP,     1'b0, C_CLAMPED,  7);
      4'd2:    c = mk(OP_SEARCH,    1'b0, C_MORE,     2);
      4'd3:    c = mk(OP_SETUP,     1'b0, C_FLAT,     7);
      4'd4:    c = mk(OP_DIV_START, 1'b0, C_NEXT,     0);
      4'd5:    c = mk(OP_NOP,       1'b0, C_DIV_BUSY, 5);
      4'd6:    c = mk(OP_ADDQ,      1'b0, C_NEXT,     0);
      4'd7:    c = mk(OP_TARGET,    1'b0, C_NEXT,     0);
      4'd8:    c = mk(OP_CLAMP,     1'b1, C_CLAMPED,  14);
      4'd9:    c = mk(OP_SEARCH,    1'b1, C_MORE,     9);
      4'd10:   c = mk(OP_SETUP,     1'b1, C_FLAT,     14);
      4'd11:   c = mk(OP_DIV_START, 1'b1, C_NEXT,     0);
      4'd12:   c = mk(OP_NOP,       1'b1, C_DIV_BUSY, 12);
      4'd13:   c = mk(OP_ADDQ,      1'b1, C_NEXT,     0);
      4'd14:   c = mk(OP_FINISH,    1'b1, C_OUT_BUSY, 14);
      4'd15:   c = mk(OP_NOP,       1'b0, C_ALWAYS,   0);
      default: c = mk(OP_NOP,       1'b0, C_ALWAYS,   0);
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/compressor_speed_from_evaporator.sv =====
// Top level: compressor speed from evaporator temperature, microcoded interpolation engine.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid_i/in_stall_o  temp_error_i, evap_temp_i, prior_speed_i
//   out      source     out_valid_o/out_stall_i compressor_speed_o, evap_target_o,
//                                              evap_difference_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction runs from acceptance to result through the breakpoint search
// (one table point per cycle) and the divider (two bits per cycle), which runs at most
// once per table. A new input is taken only when the sequencer is back at step 0,
// so the block cannot take a new transaction before it is through with the last one.
// Reset clears the sequencer, the frost flag, the output valid and loads the register
// defaults. The finished result waits in an output register, so a stalled output
// holds the sequencer only at its last step.
module compressor_speed_from_evaporator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [csfe_pkg::ERR_W-1:0]   temp_error_i,
  input  logic signed [csfe_pkg::EVAP_W-1:0]  evap_temp_i,
  input  logic [csfe_pkg::SPD_W-1:0]          prior_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [csfe_pkg::SPD_W-1:0]          compressor_speed_o,
  output logic [csfe_pkg::TGT_W-1:0]          evap_target_o,
  output logic signed [csfe_pkg::DIFF_W-1:0]  evap_difference_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csfe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [csfe_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import csfe_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;
  res_t  res, out_q;
  logic  out_valid_q;
  logic  idle, in_fire, out_busy, commit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !idle;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_busy    = out_valid_q && out_stall_i;
  assign commit      = (ctrl.op == OP_FINISH) && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frost_on  <= FROST_ON_RST;
      cfg_q.frost_off <= FROST_OFF_RST;
      cfg_q.overheat  <= OVERHEAT_RST;
      cfg_q.ramp      <= RAMP_RST;
      cfg_q.start     <= START_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FROST_ON:  cfg_q.frost_on  <= cfg_data_i[EVAP_W-1:0];
        CFG_FROST_OFF: cfg_q.frost_off <= cfg_data_i[EVAP_W-1:0];
        CFG_OVERHEAT:  cfg_q.overheat  <= cfg_data_i[EVAP_W-1:0];
        CFG_RAMP:      cfg_q.ramp      <= cfg_data_i[RAMP_W-1:0];
        CFG_START:     cfg_q.start     <= cfg_data_i[SPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  csfe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .no_in_i    (!in_valid_i),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  csfe_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .in_fire_i     (in_fire),
    .commit_i      (commit),
    .temp_error_i  (temp_error_i),
    .evap_temp_i   (evap_temp_i),
    .prior_speed_i (prior_speed_i),
    .cfg_i         (cfg_q),
    .stat_o        (stat),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign compressor_speed_o = out_q.speed;
  assign evap_target_o      = out_q.target;
  assign evap_difference_o  = out_q.diff;

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("Committed result did not reach the output register.");

  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("Sequencer did not start after an accepted transaction.");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !stat.div_busy)
    else $error("Divider busy while the sequencer waits for input.");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (compressor_speed_o <= SPEED_MAX))
    else $error("Speed command above the table maximum.");

endmodule

// ===== hdl/csfe_seq.sv =====
// Microprogram sequencer: step counter, control store and conditional jumps.
module csfe_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  csfe_pkg::stat_t stat_i,
  input  logic            no_in_i,
  input  logic            out_busy_i,
  output csfe_pkg::ctrl_t ctrl_o,
  output logic            idle_o
);
  import csfe_pkg::*;

  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_t             ctrl;
  logic              take;

  always_comb begin
    ctrl = ucode(pc_q);
    case (ctrl.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = no_in_i;
      C_CLAMPED:  take = stat_i.clamped;
      C_MORE:     take = stat_i.more;
      C_FLAT:     take = stat_i.flat;
      C_DIV_BUSY: take = stat_i.div_busy;
      C_OUT_BUSY: take = out_busy_i;
      default:    take = 1'b0;
    endcase
    pc_d = take ? ctrl.target : pc_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign idle_o = (pc_q == '0);

endmodule

// ===== hdl/csfe_div.sv =====
// Unsigned restoring divider that retires two quotient bits per cycle.
module csfe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [csfe_pkg::NUM_W-1:0] num_i,
  input  logic [csfe_pkg::DEN_W-1:0] den_i,
  output logic                       busy_o,
  output logic [csfe_pkg::NUM_W-1:0] quo_o
);
  import csfe_pkg::*;

  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] quo_q, quo_d;

  always_comb begin
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] r;
    logic [NUM_W-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[NUM_W-1]};
      q = {q[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t    = t - {1'b0, den_q};
        q[0] = 1'b1;
      end
      r = t[DEN_W-1:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(STEPS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/csfe_dp.sv =====
// Datapath: segment search, interpolation arithmetic, frost hysteresis and speed limits.
module csfe_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  csfe_pkg::ctrl_t                  ctrl_i,
  input  logic                             in_fire_i,
  input  logic                             commit_i,
  input  logic signed [csfe_pkg::ERR_W-1:0]  temp_error_i,
  input  logic signed [csfe_pkg::EVAP_W-1:0] evap_temp_i,
  input  logic [csfe_pkg::SPD_W-1:0]       prior_speed_i,
  input  csfe_pkg::cfg_t                   cfg_i,
  output csfe_pkg::stat_t                  stat_o,
  output csfe_pkg::res_t                   res_o
);
  import csfe_pkg::*;

  logic signed [XW-1:0]     x_q, diff_q;
  logic [IDX_W-1:0]         k_q;
  logic signed [YW-1:0]     res_q;
  logic signed [EVAP_W-1:0] evap_q;
  logic [SPD_W-1:0]         prior_q;
  logic [TGT_W-1:0]         target_q;
  logic [NUM_W-1:0]         num_q;
  logic [DEN_W-1:0]         den_q;
  logic                     neg_q;
  logic                     frost_q, frost_d;

  logic                     sel;
  logic signed [XW-1:0]     x0, x1, x_first, x_last, diff_next;
  logic signed [YW-1:0]     y0, y1, y_first, y_last, res_sum;
  logic signed [YW:0]       dy;
  logic signed [XW:0]       dxx, den_full;
  logic signed [YW+XW+1:0]  prod, mag;
  logic                     lo, hi, more, flat;
  logic                     div_start, div_busy;
  logic [NUM_W-1:0]         quo;
  logic signed [SW-1:0]     spd, start_s, prior_s, ramp_s;

  assign sel = ctrl_i.sel;

  always_comb begin
    x0        = tab_x(sel, k_q - IDX_W'(1));
    x1        = tab_x(sel, k_q);
    y0        = tab_y(sel, k_q - IDX_W'(1));
    y1        = tab_y(sel, k_q);
    x_first   = tab_x(sel, '0);
    x_last    = tab_x(sel, last_idx(sel));
    y_first   = tab_y(sel, '0);
    y_last    = tab_y(sel, last_idx(sel));
    lo        = x_q < x_first;
    hi        = x_q > x_last;
    more      = (k_q < last_idx(sel)) && (x_q > x1);
    flat      = x1 <= x0;
    dy        = (YW+1)'(y1) - (YW+1)'(y0);
    dxx       = (XW+1)'(x_q) - (XW+1)'(x0);
    den_full  = (XW+1)'(x1) - (XW+1)'(x0);
    prod      = dy * dxx;
    mag       = (prod < 0) ? -prod : prod;
    res_sum   = res_q + (neg_q ? -YW'(quo) : YW'(quo));
    diff_next = XW'(evap_q) - XW'(res_q);
  end

  assign div_start = (ctrl_i.op == OP_DIV_START);

  csfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_comb begin
    if (evap_q < cfg_i.frost_on) begin
      frost_d = 1'b1;
    end else if (evap_q > cfg_i.frost_off) begin
      frost_d = 1'b0;
    end else begin
      frost_d = frost_q;
    end
    start_s = signed'(SW'(cfg_i.start));
    prior_s = signed'(SW'(prior_q));
    ramp_s  = signed'(SW'(cfg_i.ramp));
    spd     = SW'(res_q);
    if (frost_d || (evap_q > cfg_i.overheat)) begin
      spd = '0;
    end
    if (spd > start_s) begin
      if (prior_s < start_s) begin
        spd = start_s;
      end else if (spd - prior_s > ramp_s) begin
        spd = prior_s + ramp_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LATCH: begin
        if (in_fire_i) begin
          x_q     <= XW'(temp_error_i);
          k_q     <= IDX_W'(1);
          evap_q  <= evap_temp_i;
          prior_q <= prior_speed_i;
        end
      end
      OP_CLAMP: begin
        if (lo) begin
          res_q <= y_first;
        end else if (hi) begin
          res_q <= y_last;
        end
      end
      OP_SEARCH: begin
        if (more) begin
          k_q <= k_q + IDX_W'(1);
        end
      end
      OP_SETUP: begin
        num_q <= mag[NUM_W-1:0];
        den_q <= den_full[DEN_W-1:0];
        neg_q <= prod < 0;
        res_q <= y0;
      end
      OP_ADDQ: begin
        res_q <= res_sum;
      end
      OP_TARGET: begin
        target_q <= res_q[TGT_W-1:0];
        diff_q   <= diff_next;
        x_q      <= diff_next;
        k_q      <= IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frost_q <= 1'b0;
    end else if (commit_i) begin
      frost_q <= frost_d;
    end
  end

  assign stat_o.clamped  = lo | hi;
  assign stat_o.more     = more;
  assign stat_o.flat     = flat;
  assign stat_o.div_busy = div_busy;

  assign res_o.speed  = spd[SPD_W-1:0];
  assign res_o.target = target_q;
  assign res_o.diff   = (diff_q[XW-1] != diff_q[XW-2]) ?
                        {diff_q[XW-1], {(DIFF_W-1){~diff_q[XW-1]}}} : diff_q[DIFF_W-1:0];

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the compressor speed block: random samples, stalls and settings.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csfe_pkg::*;

  class speed_scoreboard;
    int   frost_on;
    int   frost_off;
    int   overheat;
    int   ramp;
    int   start;
    bit   frost;
    int   bp_x [2][16];
    int   bp_y [2][16];
    int   bp_n [2];
    int   failures;
    res_t pending_results[$];

    function new();
      frost_on  = 0;
      frost_off = 10;
      overheat  = 800;
      ramp      = 40;
      start     = 2000;
      frost     = 1'b0;
      failures  = 0;
      bp_n[0]   = 10;
      bp_n[1]   = 13;
      bp_x[0] = '{-10, 0, 10, 20, 30, 40, 50, 60, 70, 80, 0, 0, 0, 0, 0, 0};
      bp_y[0] = '{105, 102, 92, 77, 60, 35, 18, 8, 2, 0, 0, 0, 0, 0, 0, 0};
      bp_x[1] = '{-40, -30, -20, -10, 0, 10, 20, 30, 40, 50, 60, 70, 80, 0, 0, 0};
      bp_y[1] = '{2000, 2000, 2000, 2000, 2000, 2000, 2300, 2850, 4100, 5000, 5550, 5900,
                  6000, 0, 0, 0};
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FROST_ON:  frost_on  = int'($signed(val[EVAP_W-1:0]));
        CFG_FROST_OFF: frost_off = int'($signed(val[EVAP_W-1:0]));
        CFG_OVERHEAT:  overheat  = int'($signed(val[EVAP_W-1:0]));
        CFG_RAMP:      ramp      = int'(val[RAMP_W-1:0]);
        CFG_START:     start     = int'(val[SPD_W-1:0]);
        default: ;
      endcase
    endfunction

    function int interpolate(int t, int x);
      int n, k, x0, x1, y0, y1;
      n = bp_n[t];
      if (x < bp_x[t][0]) return bp_y[t][0];
      if (x > bp_x[t][n-1]) return bp_y[t][n-1];
      k = 1;
      while (k < n - 1 && x > bp_x[t][k]) k++;
      x0 = bp_x[t][k-1];
      x1 = bp_x[t][k];
      y0 = bp_y[t][k-1];
      y1 = bp_y[t][k];
      if (x1 <= x0) return y0;
      return (y1 - y0) * (x - x0) / (x1 - x0) + y0;
    endfunction

    function void note_sample(logic signed [ERR_W-1:0] err, logic signed [EVAP_W-1:0] evap,
                              logic [SPD_W-1:0] prior_spd);
      int   evap_i, prior_i, tgt, diff, spd;
      res_t r;
      evap_i  = int'(evap);
      prior_i = int'(prior_spd);
      tgt     = interpolate(0, int'(err));
      diff    = evap_i - tgt;
      spd     = interpolate(1, diff);
      if (evap_i < frost_on) frost = 1'b1;
      else if (evap_i > frost_off) frost = 1'b0;
      if (frost || evap_i > overheat) spd = 0;
      if (spd > start) begin
        if (prior_i < start) spd = start;
        else if (spd - prior_i > ramp) spd = prior_i + ramp;
      end
      if (diff < -2048) diff = -2048;
      if (diff > 2047) diff = 2047;
      r.speed  = SPD_W'(spd);
      r.target = TGT_W'(tgt);
      r.diff   = DIFF_W'(diff);
      pending_results.push_back(r);
    endfunction

    function void check_command(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing expected: speed %0d target %0d diff %0d",
                   $realtime, got.speed, got.target, got.diff);
        return;
      end
      want = pending_results.pop_front();
      if (got.speed !== want.speed || got.target !== want.target || got.diff !== want.diff)
      begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: speed %0d/%0d target %0d/%0d diff %0d/%0d (exp/act)",
                   $realtime, want.speed, got.speed, want.target, got.target,
                   want.diff, got.diff);
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [ERR_W-1:0]  temp_error_i;
  logic signed [EVAP_W-1:0] evap_temp_i;
  logic [SPD_W-1:0]         prior_speed_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [SPD_W-1:0]         compressor_speed_o;
  logic [TGT_W-1:0]         evap_target_o;
  logic signed [DIFF_W-1:0] evap_difference_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  speed_scoreboard sb = new();
  bit calm;
  int cur_on, cur_off, cur_hot, cur_start;

  localparam int NUM_PHASES = 8;
  localparam int PH_ON    [NUM_PHASES] = '{0, -500, 1500, -2048, 0, 50, 0, 20};
  localparam int PH_OFF   [NUM_PHASES] = '{10, 1500, -500, 2047, 10, 120, 0, 20};
  localparam int PH_HOT   [NUM_PHASES] = '{800, 1500, -500, 2047, 800, 300, 0, 100};
  localparam int PH_RAMP  [NUM_PHASES] = '{40, 1000, 0, 1023, 40, 250, 0, 1};
  localparam int PH_START [NUM_PHASES] = '{2000, 6000, 0, 8191, 2000, 3000, 0, 6500};

  compressor_speed_from_evaporator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .temp_error_i       (temp_error_i),
    .evap_temp_i        (evap_temp_i),
    .prior_speed_i      (prior_speed_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .compressor_speed_o (compressor_speed_o),
    .evap_target_o      (evap_target_o),
    .evap_difference_o  (evap_difference_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_command('{speed: compressor_speed_o, target: evap_target_o,
                         diff: evap_difference_o});
  end

  task automatic drive_sample(input int err, input int evap, input int prior_spd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    temp_error_i  <= ERR_W'(err);
    evap_temp_i   <= EVAP_W'(evap);
    prior_speed_i <= SPD_W'(prior_spd);
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(ERR_W'(err), EVAP_W'(evap), SPD_W'(prior_spd));
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, CFG_DATA_W'(val));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_sample();
    int err, evap, prior_spd;
    case ($urandom_range(0, 9))
      0: begin
        err       = int'($signed(ERR_W'($urandom)));
        evap      = int'($signed(EVAP_W'($urandom)));
        prior_spd = int'(SPD_W'($urandom));
      end
      1: begin
        err       = int'($urandom_range(0, 4000)) - 2000;
        evap      = int'($urandom_range(0, 2000)) - 500;
        prior_spd = $urandom_range(0, 6000);
      end
      2: begin
        err       = int'($urandom_range(0, 110)) - 20;
        evap      = ($urandom_range(0, 1) ? cur_on : cur_off) + int'($urandom_range(0, 30)) - 15;
        prior_spd = $urandom_range(0, 6000);
      end
      3: begin
        err       = int'($urandom_range(0, 110)) - 20;
        evap      = cur_hot + int'($urandom_range(0, 10)) - 5;
        prior_spd = $urandom_range(0, 6000);
      end
      default: begin
        err  = int'($urandom_range(0, 110)) - 20;
        evap = int'($urandom_range(0, 250)) - 30;
        if ($urandom_range(0, 1))
          prior_spd = cur_start + int'($urandom_range(0, 200)) - 100;
        else
          prior_spd = $urandom_range(1800, 6200);
        if (prior_spd < 0) prior_spd = 0;
      end
    endcase
    drive_sample(err, evap, prior_spd);
  endtask

  initial begin : out_side
    int k;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      k = calm ? 0 : $urandom_range(0, 5);
      @(negedge clk_i);
      out_stall_i <= (k != 0);
      if (k != 0) begin
        repeat (k) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    temp_error_i  = '0;
    evap_temp_i   = '0;
    prior_speed_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_FROST_ON;
    cfg_data_i    = '0;
    calm          = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cur_on    = PH_ON[0];
    cur_off   = PH_OFF[0];
    cur_hot   = PH_HOT[0];
    cur_start = PH_START[0];
    drive_sample(-2048, 100, 6000);
    drive_sample(2047, 100, 6000);
    drive_sample(-11, 50, 0);
    drive_sample(-10, 50, 0);
    drive_sample(80, 50, 0);
    drive_sample(81, 50, 2000);
    drive_sample(35, 60, 4000);
    drive_sample(5, -2048, 3000);
    drive_sample(5, 5, 3000);
    drive_sample(5, 11, 3000);
    drive_sample(0, -1, 3000);
    drive_sample(0, 10, 3000);
    drive_sample(0, 800, 3000);
    drive_sample(0, 801, 3000);
    drive_sample(0, 2047, 8191);
    drive_sample(-2000, -500, 0);
    drive_sample(2000, 1500, 6000);
    drive_sample(40, 70, 2100);
    drive_sample(40, 70, 8191);
    drive_sample(-5, 100, 1999);
    drive_sample(20, 77, 2000);
    drive_sample(-1, 1, 5);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        cur_on    = PH_ON[ph];
        cur_off   = PH_OFF[ph];
        cur_hot   = PH_HOT[ph];
        cur_start = PH_START[ph];
        if (ph == 6) begin
          cur_on    = int'($urandom_range(0, 2000)) - 500;
          cur_off   = int'($urandom_range(0, 2000)) - 500;
          cur_hot   = int'($urandom_range(0, 2000)) - 500;
          cur_start = $urandom_range(0, 6000);
        end
        write_reg(CFG_FROST_ON, cur_on);
        write_reg(CFG_FROST_OFF, cur_off);
        write_reg(CFG_OVERHEAT, cur_hot);
        write_reg(CFG_RAMP, (ph == 6) ? int'($urandom_range(0, 1000)) : PH_RAMP[ph]);
        write_reg(CFG_START, cur_start);
      end
      for (int i = 0; i < 100; i++) begin
        calm = (i >= 80);
        random_sample();
      end
      calm = 1'b0;
    end

    drain_results();
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
